/* rtl/hapr_pkg.sv */
`timescale 1ns / 1ps

package hapr_pkg;

  // Payload offsets at or above this are counted and dropped.
  localparam int KeptPayloadBytes = 11;

  // Index of the last word of an ATT error response.
  localparam logic [3:0] ReplyLast = 4'd13;

  // HCI packet indicators
  localparam logic [7:0] PKT_ACL   = 8'h02;
  localparam logic [7:0] PKT_EVENT = 8'h04;

  // L2CAP / ATT
  localparam logic [15:0] L2CAP_ATT_CID     = 16'h0004;
  localparam logic [15:0] MOVE_L2CAP_LEN    = 16'd7;
  localparam logic [15:0] BUTTON_L2CAP_LEN  = 16'd5;
  localparam logic [15:0] SHORT_ACL_MAX     = 16'd7;
  localparam logic [15:0] MOVE_MIN_ACL      = 16'd11;
  localparam logic [15:0] BUTTON_MIN_ACL    = 16'd9;
  localparam logic [7:0]  ATT_OP_ERROR      = 8'h01;
  localparam logic [7:0]  ATT_READ_GROUP    = 8'h10;
  localparam logic [7:0]  ATT_NOTIFY        = 8'h1B;
  localparam logic [7:0]  ATT_ERR_NOT_FOUND = 8'h0A;
  localparam logic [7:0]  BTN_PRESS         = 8'h01;
  localparam logic [7:0]  BTN_RELEASE       = 8'h02;

  // Response framing
  localparam logic [3:0] RSP_HANDLE_FLAGS = 4'h2;  // packet boundary flag, 0x2000
  localparam logic [7:0] RSP_ACL_LEN      = 8'h09;
  localparam logic [7:0] RSP_L2CAP_LEN    = 8'h05;

  // Pointer reset position
  localparam logic [14:0] CURSOR_X_RESET = 15'd960;
  localparam logic [14:0] CURSOR_Y_RESET = 15'd540;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_EV_CODE,
    PH_EV_LEN,
    PH_EV_SKIP,
    PH_H1,
    PH_H2,
    PH_L1,
    PH_L2,
    PH_PAYLOAD
  } phase_t;

  typedef enum logic [2:0] {
    CFG_LINK_HANDLE   = 3'd0,
    CFG_NOTIFY_HANDLE = 3'd1,
    CFG_X_MIN         = 3'd2,
    CFG_Y_MIN         = 3'd3,
    CFG_X_MAX         = 3'd4,
    CFG_Y_MAX         = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [11:0] link_handle;
    logic [7:0]  notify_handle;
    logic [14:0] x_min;
    logic [14:0] y_min;
    logic [14:0] x_max;
    logic [14:0] y_max;
  } cfg_t;

  // One pending run of results: an error response or a pointer update.
  typedef struct packed {
    logic        is_pointer;
    logic [11:0] link;
    logic [15:0] target;
    logic [14:0] x;
    logic [14:0] y;
    logic [15:0] buttons;
  } run_t;

  function automatic logic [7:0] reply_byte(input logic [3:0] idx, input logic [11:0] link,
                                            input logic [15:0] target);
    logic [7:0] b;
    case (idx)
      4'd0:    b = PKT_ACL;
      4'd1:    b = link[7:0];
      4'd2:    b = {RSP_HANDLE_FLAGS, link[11:8]};
      4'd3:    b = RSP_ACL_LEN;
      4'd4:    b = 8'h00;
      4'd5:    b = RSP_L2CAP_LEN;
      4'd6:    b = 8'h00;
      4'd7:    b = L2CAP_ATT_CID[7:0];
      4'd8:    b = L2CAP_ATT_CID[15:8];
      4'd9:    b = ATT_OP_ERROR;
      4'd10:   b = ATT_READ_GROUP;
      4'd11:   b = target[7:0];
      4'd12:   b = target[15:8];
      4'd13:   b = ATT_ERR_NOT_FOUND;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Raise to lo first, then lower to hi, so hi wins when hi < lo.
  function automatic logic [14:0] clamp_axis(input logic [15:0] v, input logic [14:0] lo,
                                             input logic [14:0] hi);
    logic signed [16:0] r;
    logic signed [16:0] los;
    logic signed [16:0] his;
    r   = {v[15], v};
    los = {2'b00, lo};
    his = {2'b00, hi};
    if (r < los) r = los;
    if (r > his) r = his;
    return r[14:0];
  endfunction

endpackage

/* rtl/hapr_parser.sv */
`timescale 1ns / 1ps

module hapr_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      rx_byte,
  input  hapr_pkg::cfg_t  cfg,
  output logic            desc_valid,
  output hapr_pkg::run_t  desc,
  input  logic            desc_pop
);
  import hapr_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] byte_count, byte_count_next, cnt_inc;
  logic [11:0] packet_link, packet_link_next;
  logic [15:0] acl_length, acl_length_next;
  logic [15:0] l2cap_length, l2cap_length_next;
  logic [15:0] channel_id, channel_id_next;
  logic [7:0]  att_code, att_code_next;
  logic [15:0] att_target, att_target_next;
  logic [7:0]  value_bytes [4];
  logic [7:0]  value_bytes_next [4];
  logic [14:0] cursor_x, cursor_x_next;
  logic [14:0] cursor_y, cursor_y_next;
  logic [15:0] buttons, buttons_next;
  logic        finish, emit, is_ptr, link_match;
  logic        accept;

  // holding register frees up in the same cycle the emitter takes it
  assign in_stall = desc_valid && !desc_pop;
  assign accept   = in_valid && !in_stall;
  assign cnt_inc  = byte_count + 16'd1;

  // field capture and framing
  always_comb begin
    phase_next        = phase;
    byte_count_next   = byte_count;
    packet_link_next  = packet_link;
    acl_length_next   = acl_length;
    l2cap_length_next = l2cap_length;
    channel_id_next   = channel_id;
    att_code_next     = att_code;
    att_target_next   = att_target;
    value_bytes_next  = value_bytes;
    finish            = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (rx_byte == PKT_EVENT) phase_next = PH_EV_CODE;
        else if (rx_byte == PKT_ACL) phase_next = PH_H1;
      end
      PH_EV_CODE: phase_next = PH_EV_LEN;
      PH_EV_LEN: begin
        acl_length_next = {8'h00, rx_byte};
        byte_count_next = 16'd0;
        phase_next      = (rx_byte == 8'h00) ? PH_IDLE : PH_EV_SKIP;
      end
      PH_EV_SKIP: begin
        byte_count_next = cnt_inc;
        if (cnt_inc >= acl_length) phase_next = PH_IDLE;
      end
      PH_H1: begin
        packet_link_next = {4'h0, rx_byte};
        phase_next       = PH_H2;
      end
      PH_H2: begin
        // top nibble carries the boundary/broadcast flags
        packet_link_next = {rx_byte[3:0], packet_link[7:0]};
        phase_next       = PH_L1;
      end
      PH_L1: begin
        acl_length_next = {8'h00, rx_byte};
        phase_next      = PH_L2;
      end
      PH_L2: begin
        acl_length_next   = {rx_byte, acl_length[7:0]};
        byte_count_next   = 16'd0;
        l2cap_length_next = 16'd0;
        channel_id_next   = 16'd0;
        att_code_next     = 8'h00;
        att_target_next   = 16'd0;
        phase_next        = ({rx_byte, acl_length[7:0]} == 16'd0) ? PH_IDLE : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        case (byte_count)
          16'd0: l2cap_length_next = {8'h00, rx_byte};
          16'd1: l2cap_length_next = {rx_byte, l2cap_length[7:0]};
          16'd2: channel_id_next   = {8'h00, rx_byte};
          16'd3: channel_id_next   = {rx_byte, channel_id[7:0]};
          16'd4: att_code_next     = rx_byte;
          16'd5: att_target_next   = {8'h00, rx_byte};
          16'd6: att_target_next   = {rx_byte, att_target[7:0]};
          default: begin
            if (byte_count inside {[16'd7:16'd10]} && byte_count < 16'(KeptPayloadBytes))
              value_bytes_next[2'(byte_count[1:0] - 2'd3)] = rx_byte;
          end
        endcase
        byte_count_next = cnt_inc;
        if (cnt_inc >= acl_length) begin
          phase_next = PH_IDLE;
          finish     = 1'b1;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  // end-of-packet decision on the fields as they stand after this byte
  always_comb begin
    cursor_x_next = cursor_x;
    cursor_y_next = cursor_y;
    buttons_next  = buttons;
    emit          = 1'b0;
    is_ptr        = 1'b0;
    link_match    = acl_length > SHORT_ACL_MAX && packet_link == cfg.link_handle &&
                    channel_id_next == L2CAP_ATT_CID;
    if (finish && link_match) begin
      if (att_code_next == ATT_READ_GROUP) begin
        emit = 1'b1;
      end else if (att_code_next == ATT_NOTIFY &&
                   att_target_next == {8'h00, cfg.notify_handle}) begin
        if (l2cap_length_next == MOVE_L2CAP_LEN && acl_length >= MOVE_MIN_ACL) begin
          cursor_x_next = clamp_axis({value_bytes_next[1], value_bytes_next[0]},
                                     cfg.x_min, cfg.x_max);
          cursor_y_next = clamp_axis({value_bytes_next[3], value_bytes_next[2]},
                                     cfg.y_min, cfg.y_max);
          emit   = 1'b1;
          is_ptr = 1'b1;
        end else if (l2cap_length_next == BUTTON_L2CAP_LEN &&
                     acl_length >= BUTTON_MIN_ACL) begin
          if (value_bytes_next[0] == BTN_PRESS)
            buttons_next = buttons | {8'h00, value_bytes_next[1]};
          else if (value_bytes_next[0] == BTN_RELEASE)
            buttons_next = buttons ^ {8'h00, value_bytes_next[1]};
          emit   = 1'b1;
          is_ptr = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      byte_count   <= 16'd0;
      packet_link  <= 12'd0;
      acl_length   <= 16'd0;
      l2cap_length <= 16'd0;
      channel_id   <= 16'd0;
      att_code     <= 8'h00;
      att_target   <= 16'd0;
      cursor_x     <= CURSOR_X_RESET;
      cursor_y     <= CURSOR_Y_RESET;
      buttons      <= 16'd0;
    end else if (accept) begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      packet_link  <= packet_link_next;
      acl_length   <= acl_length_next;
      l2cap_length <= l2cap_length_next;
      channel_id   <= channel_id_next;
      att_code     <= att_code_next;
      att_target   <= att_target_next;
      cursor_x     <= cursor_x_next;
      cursor_y     <= cursor_y_next;
      buttons      <= buttons_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) value_bytes <= value_bytes_next;
  end

  // a new run may land in the same cycle the old one is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      desc_valid <= 1'b0;
    end else if (accept && emit) begin
      desc_valid <= 1'b1;
    end else if (desc_pop) begin
      desc_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      desc.is_pointer <= is_ptr;
      desc.link       <= packet_link;
      desc.target     <= att_target_next;
      desc.x          <= cursor_x_next;
      desc.y          <= cursor_y_next;
      desc.buttons    <= buttons_next;
    end
  end

  // a run is only raised by the last byte of a packet, so the framer is idle
  a_desc_idle: assert property (@(posedge clk) disable iff (rst)
    desc_valid |-> phase == PH_IDLE)
    else $error("pending run while framer not idle");

  a_desc_from_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(desc_valid) |-> $past(accept))
    else $error("run raised without an accepted word");

  a_stall_pending: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> desc_valid)
    else $error("input stalled with no pending run");

endmodule

/* rtl/hapr_emitter.sv */
`timescale 1ns / 1ps

module hapr_emitter (
  input  logic            clk,
  input  logic            rst,
  input  logic            desc_valid,
  input  hapr_pkg::run_t  desc,
  output logic            desc_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            result_kind,
  output logic [7:0]      tx_byte,
  output logic            last_of_run,
  output logic [14:0]     pointer_x,
  output logic [14:0]     pointer_y,
  output logic [15:0]     button_mask
);
  import hapr_pkg::*;

  logic        run_valid;
  run_t        run;
  logic [3:0]  idx;
  logic        out_fire, run_last, take;

  assign out_fire = run_valid && !out_stall;
  assign run_last = run.is_pointer || idx == ReplyLast;
  assign take     = !run_valid || (out_fire && run_last);
  assign desc_pop = desc_valid && take;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      idx       <= 4'd0;
    end else if (desc_pop) begin
      run_valid <= 1'b1;
      idx       <= 4'd0;
    end else if (out_fire && run_last) begin
      run_valid <= 1'b0;
      idx       <= 4'd0;
    end else if (out_fire) begin
      idx <= idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (desc_pop) run <= desc;
  end

  assign out_valid   = run_valid;
  assign result_kind = run.is_pointer;
  assign tx_byte     = run.is_pointer ? 8'h00 : reply_byte(idx, run.link, run.target);
  assign last_of_run = run_last;
  assign pointer_x   = run.x;
  assign pointer_y   = run.y;
  assign button_mask = run.buttons;

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= ReplyLast)
    else $error("response index past last word");

  a_idx_resp_only: assert property (@(posedge clk) disable iff (rst)
    idx != 4'd0 |-> run_valid && !run.is_pointer)
    else $error("index moved outside a response run");

  a_last_rewinds: assert property (@(posedge clk) disable iff (rst)
    out_fire && run_last |=> idx == 4'd0)
    else $error("index not rewound after last word");

endmodule

/* rtl/hci_acl_pointer_report_parser.sv */
`timescale 1ns / 1ps

// HCI UART receive parser for a pointer peripheral. One rx_byte word is taken per
// clock while in_stall is low. Event packets (0x04) are skipped by their length
// byte; ACL packets (0x02) are framed and their L2CAP/ATT header fields captured.
// On the last payload word of a packet for link_handle on channel 4, an ATT Read
// By Group Type request (0x10) produces a 14-word error response run (result_kind
// 0, tx_byte valid), and a notification (0x1b) to notify_handle produces one
// pointer update word (result_kind 1): a 7-byte L2CAP payload moves the pointer to
// the signed x/y clamped into [min, max] (max wins if below min), a 5-byte one ORs
// (press) or XORs (release) the button byte into the mask. ACL payloads of 7 bytes
// or less never produce output. Every output word carries the pointer state as of
// the end of its packet. Rate: one input word per clock unless in_stall is high.
// Results pass through a one-run holding register into the output run register, so
// input keeps flowing while a run drains; input stalls only when a second finished
// packet is waiting behind a run still being sent (a response run takes 14 output
// words). Configuration registers take effect on the next clock; the user must see
// that they are written only when the block is idle, which the block does not enforce.

module hci_acl_pointer_report_parser (
  input  logic         clk,
  input  logic         rst,
  // configuration
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [14:0]  cfg_data,
  // receive words
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [7:0]   rx_byte,
  // result words
  output logic         out_valid,
  input  logic         out_stall,
  output logic         result_kind,
  output logic [7:0]   tx_byte,
  output logic         last_of_run,
  output logic [14:0]  pointer_x,
  output logic [14:0]  pointer_y,
  output logic [15:0]  button_mask
);
  import hapr_pkg::*;

  cfg_t cfg;
  run_t desc;
  logic desc_valid;
  logic desc_pop;

  // Config register file; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.link_handle   <= 12'd0;
      cfg.notify_handle <= ATT_NOTIFY;
      cfg.x_min         <= 15'd0;
      cfg.y_min         <= 15'd0;
      cfg.x_max         <= 15'd1920;
      cfg.y_max         <= 15'd1080;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LINK_HANDLE:   cfg.link_handle   <= cfg_data[11:0];
        CFG_NOTIFY_HANDLE: cfg.notify_handle <= cfg_data[7:0];
        CFG_X_MIN:         cfg.x_min         <= cfg_data;
        CFG_Y_MIN:         cfg.y_min         <= cfg_data;
        CFG_X_MAX:         cfg.x_max         <= cfg_data;
        CFG_Y_MAX:         cfg.y_max         <= cfg_data;
        default: ;
      endcase
    end
  end

  // Framer, field capture, pointer state and end-of-packet decision.
  hapr_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .cfg        (cfg),
    .desc_valid (desc_valid),
    .desc       (desc),
    .desc_pop   (desc_pop)
  );

  // Output run register: walks a response run word by word.
  hapr_emitter u_emitter (
    .clk         (clk),
    .rst         (rst),
    .desc_valid  (desc_valid),
    .desc        (desc),
    .desc_pop    (desc_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .tx_byte     (tx_byte),
    .last_of_run (last_of_run),
    .pointer_x   (pointer_x),
    .pointer_y   (pointer_y),
    .button_mask (button_mask)
  );

endmodule

/* tb/hci_report_checker.sv */
`timescale 1ns / 1ps

module hci_report_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        result_kind,
  input  logic [7:0]  tx_byte,
  input  logic        last_of_run,
  input  logic [14:0] pointer_x,
  input  logic [14:0] pointer_y,
  input  logic [15:0] button_mask,
  output int          mismatches,
  output int          waiting
);
  import hapr_pkg::*;

  localparam logic KIND_TX      = 1'b0;
  localparam logic KIND_POINTER = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx;
    logic        last;
    logic [14:0] x;
    logic [14:0] y;
    logic [15:0] btn;
  } report_word_t;

  report_word_t expected_words[$];
  int fails;

  // mirror of the parser
  cfg_t        cfg;
  phase_t      phase;
  logic [15:0] seen;
  logic [11:0] link_id;
  logic [15:0] frame_len;
  logic [15:0] l2cap_len;
  logic [15:0] chan;
  logic [7:0]  opcode;
  logic [15:0] att_handle;
  logic [7:0]  value_b[4];
  logic [14:0] cur_x;
  logic [14:0] cur_y;
  logic [15:0] buttons;

  function automatic logic [14:0] bound_axis(input logic [15:0] raw, input logic [14:0] lo,
                                             input logic [14:0] hi);
    int v;
    v = $signed(raw);
    if (v < int'(lo)) v = int'(lo);
    if (v > int'(hi)) v = int'(hi);
    return 15'(v);
  endfunction

  task automatic push_word(input logic kind, input logic [7:0] tx, input logic last);
    report_word_t w;
    w.kind = kind;
    w.tx   = tx;
    w.last = last;
    w.x    = cur_x;
    w.y    = cur_y;
    w.btn  = buttons;
    expected_words.push_back(w);
  endtask

  // last payload word of an ACL packet
  task automatic close_packet();
    logic [7:0] rsp[14];
    if (frame_len <= SHORT_ACL_MAX || link_id != cfg.link_handle || chan != L2CAP_ATT_CID)
      return;
    if (opcode == ATT_READ_GROUP) begin
      rsp = '{PKT_ACL, link_id[7:0], {RSP_HANDLE_FLAGS, link_id[11:8]}, RSP_ACL_LEN, 8'h00,
              RSP_L2CAP_LEN, 8'h00, L2CAP_ATT_CID[7:0], L2CAP_ATT_CID[15:8], ATT_OP_ERROR,
              ATT_READ_GROUP, att_handle[7:0], att_handle[15:8], ATT_ERR_NOT_FOUND};
      for (int i = 0; i < 14; i++) push_word(KIND_TX, rsp[i], i == ReplyLast);
      return;
    end
    if (opcode != ATT_NOTIFY || att_handle != {8'h00, cfg.notify_handle}) return;
    if (l2cap_len == MOVE_L2CAP_LEN && frame_len >= MOVE_MIN_ACL) begin
      cur_x = bound_axis({value_b[1], value_b[0]}, cfg.x_min, cfg.x_max);
      cur_y = bound_axis({value_b[3], value_b[2]}, cfg.y_min, cfg.y_max);
      push_word(KIND_POINTER, 8'h00, 1'b1);
    end else if (l2cap_len == BUTTON_L2CAP_LEN && frame_len >= BUTTON_MIN_ACL) begin
      if (value_b[0] == BTN_PRESS) buttons = buttons | {8'h00, value_b[1]};
      else if (value_b[0] == BTN_RELEASE) buttons = buttons ^ {8'h00, value_b[1]};
      push_word(KIND_POINTER, 8'h00, 1'b1);
    end
  endtask

  task automatic parse_word(input logic [7:0] b);
    case (phase)
      PH_IDLE: begin
        if (b == PKT_EVENT) phase = PH_EV_CODE;
        else if (b == PKT_ACL) phase = PH_H1;
      end
      PH_EV_CODE: phase = PH_EV_LEN;
      PH_EV_LEN: begin
        frame_len = {8'h00, b};
        seen      = 16'd0;
        phase     = (b == 8'h00) ? PH_IDLE : PH_EV_SKIP;
      end
      PH_EV_SKIP: begin
        seen = seen + 16'd1;
        if (seen >= frame_len) phase = PH_IDLE;
      end
      PH_H1: begin
        link_id = {4'h0, b};
        phase   = PH_H2;
      end
      PH_H2: begin
        link_id[11:8] = b[3:0];  // flag nibble dropped
        phase         = PH_L1;
      end
      PH_L1: begin
        frame_len = {8'h00, b};
        phase     = PH_L2;
      end
      PH_L2: begin
        frame_len[15:8] = b;
        seen       = 16'd0;
        l2cap_len  = 16'd0;
        chan       = 16'd0;
        opcode     = 8'h00;
        att_handle = 16'd0;
        phase      = (frame_len == 16'd0) ? PH_IDLE : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        case (seen)
          16'd0: l2cap_len[7:0]   = b;
          16'd1: l2cap_len[15:8]  = b;
          16'd2: chan[7:0]        = b;
          16'd3: chan[15:8]       = b;
          16'd4: opcode           = b;
          16'd5: att_handle[7:0]  = b;
          16'd6: att_handle[15:8] = b;
          default: begin
            if (seen < KeptPayloadBytes && seen - 16'd7 < 16'd4)
              value_b[2'(seen - 16'd7)] = b;
          end
        endcase
        seen = seen + 16'd1;
        if (seen >= frame_len) begin
          phase = PH_IDLE;
          close_packet();
        end
      end
      default: phase = PH_IDLE;
    endcase
  endtask

  task automatic check_field(input string field, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: mismatch on %s: expected %h, actual %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    report_word_t w;
    if (rst) begin
      cfg.link_handle   = 12'd0;
      cfg.notify_handle = 8'd27;
      cfg.x_min         = 15'd0;
      cfg.y_min         = 15'd0;
      cfg.x_max         = 15'd1920;
      cfg.y_max         = 15'd1080;
      phase      = PH_IDLE;
      seen       = 16'd0;
      link_id    = 12'd0;
      frame_len  = 16'd0;
      l2cap_len  = 16'd0;
      chan       = 16'd0;
      opcode     = 8'h00;
      att_handle = 16'd0;
      cur_x      = CURSOR_X_RESET;
      cur_y      = CURSOR_Y_RESET;
      buttons    = 16'd0;
      fails      = 0;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LINK_HANDLE:   cfg.link_handle   = cfg_data[11:0];
          CFG_NOTIFY_HANDLE: cfg.notify_handle = cfg_data[7:0];
          CFG_X_MIN:         cfg.x_min         = cfg_data;
          CFG_Y_MIN:         cfg.y_min         = cfg_data;
          CFG_X_MAX:         cfg.x_max         = cfg_data;
          CFG_Y_MAX:         cfg.y_max         = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) parse_word(rx_byte);
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          fails++;
          $display("%0t: unexpected result word: expected none, actual kind %0d tx %h",
                   $time, result_kind, tx_byte);
        end else begin
          w = expected_words.pop_front();
          check_field("result_kind", 16'(w.kind), 16'(result_kind));
          check_field("tx_byte", 16'(w.tx), 16'(tx_byte));
          check_field("last_of_run", 16'(w.last), 16'(last_of_run));
          check_field("pointer_x", 16'(w.x), 16'(pointer_x));
          check_field("pointer_y", 16'(w.y), 16'(pointer_y));
          check_field("button_mask", w.btn, button_mask);
        end
      end
    end
    mismatches <= fails;
    waiting    <= expected_words.size();
  end

endmodule

/* tb/hci_acl_pointer_report_parser_test.sv */
`timescale 1ns / 1ps

// Stimulus side of the parser bench. The checker sits beside the DUT and does all
// prediction and comparison; this module only produces UART byte streams, drives
// the receiver's stalls, writes the configuration between phases and gives the verdict.
module hci_acl_pointer_report_parser_test;
  import hapr_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [14:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic        result_kind;
  logic [7:0]  tx_byte;
  logic        last_of_run;
  logic [14:0] pointer_x;
  logic [14:0] pointer_y;
  logic [15:0] button_mask;

  int mismatches;
  int waiting;

  cfg_t active;      // settings the block holds right now, used to aim packets
  bit   calm;        // both sides stop idling while set
  bit   hold_req;    // asks the receiver for a long hold-off
  int   acl_words;   // ACL words sent in the current random phase

  hci_acl_pointer_report_parser DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .tx_byte     (tx_byte),
    .last_of_run (last_of_run),
    .pointer_x   (pointer_x),
    .pointer_y   (pointer_y),
    .button_mask (button_mask)
  );

  hci_report_checker report_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .tx_byte     (tx_byte),
    .last_of_run (last_of_run),
    .pointer_x   (pointer_x),
    .pointer_y   (pointer_y),
    .button_mask (button_mask),
    .mismatches  (mismatches),
    .waiting     (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: random stalls, or one long hold-off on request so that two finished
  // packets pile up behind a response run and the block pushes back on rx words.
  initial begin : receiver
    int held;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        for (held = 0; held < 400; held++) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 14);
      end
    end
  end

  // One rx word: optional idle gap, then hold it until taken.
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_event(input logic [7:0] code, input int len);
    send_byte(PKT_EVENT);
    send_byte(code);
    send_byte(8'(len));
    repeat (len) send_byte(8'($urandom));
  endtask

  // Full ACL frame. value carries the four value words little-endian:
  // {y, x} for a move, {.., mask, event} for a button report.
  task automatic send_acl(input logic [11:0] link, input logic [15:0] len,
                          input logic [15:0] l2, input logic [15:0] cid,
                          input logic [7:0] op, input logic [15:0] target,
                          input logic [31:0] value);
    logic [7:0] b;
    send_byte(PKT_ACL);
    send_byte(link[7:0]);
    send_byte({4'($urandom), link[11:8]});  // flag nibble must not matter
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    for (int i = 0; i < int'(len); i++) begin
      case (i)
        0: b = l2[7:0];
        1: b = l2[15:8];
        2: b = cid[7:0];
        3: b = cid[15:8];
        4: b = op;
        5: b = target[7:0];
        6: b = target[15:8];
        7, 8, 9, 10: b = value[8*(i-7) +: 8];
        default: b = 8'($urandom);
      endcase
      send_byte(b);
    end
    acl_words += 5 + int'(len);
  endtask

  task automatic put_reg(input cfg_index_t idx, input logic [14:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  task automatic program_block(input logic [11:0] link, input logic [7:0] notify,
                               input logic [14:0] xlo, input logic [14:0] ylo,
                               input logic [14:0] xhi, input logic [14:0] yhi);
    put_reg(CFG_LINK_HANDLE, {3'b000, link});
    put_reg(CFG_NOTIFY_HANDLE, {7'd0, notify});
    put_reg(CFG_X_MIN, xlo);
    put_reg(CFG_Y_MIN, ylo);
    put_reg(CFG_X_MAX, xhi);
    put_reg(CFG_Y_MAX, yhi);
    cfg_we <= 1'b0;
    active.link_handle   = link;
    active.notify_handle = notify;
    active.x_min         = xlo;
    active.y_min         = ylo;
    active.x_max         = xhi;
    active.y_max         = yhi;
  endtask

  // Drain: wait until every expected word is back, then let packets that end
  // without results run out as well.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic int slack();
    return ($urandom_range(3) == 0) ? $urandom_range(1, 8) : 0;
  endfunction

  // coordinate near the clamp edges, at the 16-bit extremes, or anywhere
  function automatic logic [15:0] axis_value(input logic [14:0] lo, input logic [14:0] hi);
    case ($urandom_range(6))
      0: return {1'b0, lo};
      1: return {1'b0, hi};
      2: return {1'b0, hi} + 16'd1;
      3: return {1'b0, lo} - 16'd1;
      4: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      5: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_frame();
    int          pick;
    int          shape;
    logic [11:0] link;
    logic [15:0] len;
    logic [15:0] l2;
    logic [15:0] cid;
    logic [15:0] target;
    logic [7:0]  op;
    logic [7:0]  b;
    logic [31:0] value;
    pick = $urandom_range(99);
    if (pick >= 95) begin
      // stray word while idle: anything but a packet type
      do b = 8'($urandom); while (b == PKT_ACL || b == PKT_EVENT);
      send_byte(b);
      return;
    end
    if (pick >= 80) begin
      send_event(8'($urandom), $urandom_range(20));
      return;
    end
    if (pick < 30) shape = 0;
    else if (pick < 50) shape = 1;
    else if (pick < 65) shape = 2;
    else shape = $urandom_range(2);
    link   = active.link_handle;
    cid    = L2CAP_ATT_CID;
    op     = ATT_NOTIFY;
    target = {8'h00, active.notify_handle};
    value  = $urandom;
    case (shape)
      0: begin  // move
        l2    = MOVE_L2CAP_LEN;
        len   = MOVE_MIN_ACL + 16'(slack());
        value = {axis_value(active.y_min, active.y_max), axis_value(active.x_min, active.x_max)};
      end
      1: begin  // button
        l2  = BUTTON_L2CAP_LEN;
        len = BUTTON_MIN_ACL + 16'(slack());
        case ($urandom_range(3))
          0, 1: value[7:0] = BTN_PRESS;
          2:    value[7:0] = BTN_RELEASE;
          default: ;
        endcase
      end
      default: begin  // read-by-group request
        op     = ATT_READ_GROUP;
        l2     = 16'($urandom_range(3, 12));
        len    = SHORT_ACL_MAX + 16'd1 + 16'(slack());
        target = 16'($urandom);
      end
    endcase
    // broken packets: one field spoiled
    if (pick >= 65) begin
      case ($urandom_range(5))
        0: link = link ^ (12'h001 << $urandom_range(11));
        1: cid = cid ^ (16'h0001 << $urandom_range(15));
        2: len = 16'($urandom_range(0, int'(len) - 1));
        3: l2 = l2 ^ (16'h0001 << $urandom_range(15));
        4: target[15:8] = 8'($urandom_range(1, 255));
        default: begin
          do op = 8'($urandom); while (op == ATT_READ_GROUP || op == ATT_NOTIFY);
        end
      endcase
    end
    send_acl(link, len, l2, cid, op, target, value);
  endtask

  task automatic random_frames(input int budget);
    acl_words = 0;
    while (acl_words < budget) random_frame();
  endtask

  // Hand-picked packets covering each parser corner once.
  task automatic directed();
    logic [11:0] lk;
    logic [15:0] nt;
    lk = active.link_handle;
    nt = {8'h00, active.notify_handle};
    // unknown packet types are dropped
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    // empty event, then a short one
    send_event(8'h0E, 0);
    send_event(8'h3E, 12);
    // empty ACL payload, and a short one that would otherwise answer
    send_acl(lk, 16'd0, 16'd0, 16'd0, 8'h00, 16'd0, 32'd0);
    send_acl(lk, SHORT_ACL_MAX, 16'd3, L2CAP_ATT_CID, ATT_READ_GROUP, 16'h0001, 32'd0);
    // error response; the requested handle is mirrored back
    send_acl(lk, SHORT_ACL_MAX + 16'd1, 16'd4, L2CAP_ATT_CID, ATT_READ_GROUP, 16'hABCD, 32'd0);
    // same low handle byte, other high nibble: no match
    send_acl(lk ^ 12'h300, 16'd8, 16'd4, L2CAP_ATT_CID, ATT_READ_GROUP, 16'h1234, 32'd0);
    // wrong channel
    send_acl(lk, MOVE_MIN_ACL, MOVE_L2CAP_LEN, 16'h0104, ATT_NOTIFY, nt, 32'h0100_0100);
    // moves: above max / negative, then -1 and in range
    send_acl(lk, MOVE_MIN_ACL, MOVE_L2CAP_LEN, L2CAP_ATT_CID, ATT_NOTIFY, nt, 32'h8000_7FFF);
    send_acl(lk, MOVE_MIN_ACL, MOVE_L2CAP_LEN, L2CAP_ATT_CID, ATT_NOTIFY, nt, 32'h01F4_FFFF);
    // truncated move
    send_acl(lk, MOVE_MIN_ACL - 16'd1, MOVE_L2CAP_LEN, L2CAP_ATT_CID, ATT_NOTIFY, nt, 32'd0);
    // press, release, unknown button event (update still sent)
    send_acl(lk, BUTTON_MIN_ACL, BUTTON_L2CAP_LEN, L2CAP_ATT_CID, ATT_NOTIFY, nt,
             {16'h0, 8'hA5, BTN_PRESS});
    send_acl(lk, BUTTON_MIN_ACL, BUTTON_L2CAP_LEN, L2CAP_ATT_CID, ATT_NOTIFY, nt,
             {16'h0, 8'hFF, BTN_RELEASE});
    send_acl(lk, BUTTON_MIN_ACL, BUTTON_L2CAP_LEN, L2CAP_ATT_CID, ATT_NOTIFY, nt,
             {16'h0, 8'h0F, 8'h03});
    // truncated button
    send_acl(lk, BUTTON_MIN_ACL - 16'd1, BUTTON_L2CAP_LEN, L2CAP_ATT_CID, ATT_NOTIFY, nt,
             {16'h0, 8'h01, BTN_PRESS});
    // other L2CAP length, nonzero handle high byte, other opcode
    send_acl(lk, MOVE_MIN_ACL, 16'd6, L2CAP_ATT_CID, ATT_NOTIFY, nt, 32'h0010_0010);
    send_acl(lk, MOVE_MIN_ACL, MOVE_L2CAP_LEN, L2CAP_ATT_CID, ATT_NOTIFY, nt | 16'h0100,
             32'h0010_0010);
    send_acl(lk, MOVE_MIN_ACL, MOVE_L2CAP_LEN, L2CAP_ATT_CID, 8'h52, nt, 32'h0010_0010);
    // long payload, bytes past the kept window only counted
    send_acl(lk, 16'd20, MOVE_L2CAP_LEN, L2CAP_ATT_CID, ATT_NOTIFY, nt, 32'h0100_0200);
  endtask

  // Receiver holds off while several answering packets go in back to back.
  task automatic pressure();
    hold_req = 1'b1;
    repeat (3)
      send_acl(active.link_handle, 16'd8 + 16'(slack()), 16'd4, L2CAP_ATT_CID, ATT_READ_GROUP,
               16'($urandom), 32'd0);
    send_acl(active.link_handle, MOVE_MIN_ACL, MOVE_L2CAP_LEN, L2CAP_ATT_CID, ATT_NOTIFY,
             {8'h00, active.notify_handle}, $urandom);
  endtask

  initial begin : stimulus
    logic [14:0] lo_x;
    logic [14:0] lo_y;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_LINK_HANDLE;
    cfg_data  <= 15'd0;
    in_valid  <= 1'b0;
    rx_byte   <= 8'h00;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // phase 1: ordinary screen bounds, hand-picked corners then random traffic
    program_block(12'h123, ATT_NOTIFY, 15'd0, 15'd0, 15'd1920, 15'd1080);
    directed();
    random_frames(18);
    settle();

    // phase 2: top handle, y max below y min, x up to the full range
    program_block(12'hFFF, 8'h3B, 15'd100, 15'h7FFF, 15'h7FFF, 15'd0);
    random_frames(18);
    settle();

    // phase 3: zero handle and notify handle, pinned x; no idling on either side
    calm = 1'b1;
    program_block(12'h000, 8'h00, 15'd0, 15'd0, 15'd0, 15'h7FFF);
    random_frames(18);
    settle();
    calm = 1'b0;

    // phase 4: random window and handle, with a back-pressure episode
    lo_x = 15'($urandom_range(2000));
    lo_y = 15'($urandom_range(2000));
    program_block(12'($urandom), 8'hFF, lo_x, lo_y, lo_x + 15'($urandom_range(3000)),
                  lo_y + 15'($urandom_range(3000)));
    pressure();
    random_frames(18);
    settle();

    repeat (8) @(posedge clk);
    if (mismatches == 0 && waiting == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/hapr_pkg.sv
rtl/hapr_parser.sv
rtl/hapr_emitter.sv
rtl/hci_acl_pointer_report_parser.sv
tb/hci_report_checker.sv
tb/hci_acl_pointer_report_parser_test.sv
